// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define CHK_SAME(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// next-cycle implication, off during reset
`define CHK_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

// ----- hw/rtl/rttc_pkg.sv -----
// Types and constants for the rear time-to-collision unit
`timescale 1ns / 1ps
`default_nettype none
package rttc_pkg;
    localparam int D2_W  = 18;
    localparam int V_W   = 17;
    localparam int A_W   = 13;
    localparam int MAG_W = 17;
    localparam int CFG_W = 14;
    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] CFG_AXLE_OFFSET = 3'd0;
    localparam logic [IDX_W-1:0] CFG_HOST_LENGTH = 3'd1;
    localparam logic [IDX_W-1:0] CFG_DEFAULT_TTC = 3'd2;
    localparam logic [IDX_W-1:0] CFG_LATENCY     = 3'd3;
    localparam logic [IDX_W-1:0] CFG_SPEED_BAND  = 3'd4;
    localparam logic [IDX_W-1:0] CFG_ACCEL_BAND  = 3'd5;

    typedef enum logic [2:0] {
        PATH_AHEAD       = 3'd0,
        PATH_NOT_CLOSING = 3'd1,
        PATH_LINEAR      = 3'd2,
        PATH_ROOT        = 3'd3,
        PATH_NO_REAL     = 3'd4,
        PATH_NO_POS      = 3'd5
    } t_path;

    typedef struct packed {
        logic             valid;
        t_path            path;
        logic [MAG_W-1:0] dabs;
        logic [MAG_W-1:0] uv;
    } t_meta;
endpackage
`default_nettype wire

// ----- hw/rtl/rttc_sqrt_cell.sv -----
// One square-root cell: resolves one root bit from the next radicand bit pair
`timescale 1ns / 1ps
`default_nettype none
module rttc_sqrt_cell
    import rttc_pkg::*;
#(
    parameter int RB = 21
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire t_meta           i_meta,
    input  wire logic [2*RB-1:0] i_rad,
    input  wire logic [RB+1:0]   i_rem,
    input  wire logic [RB-1:0]   i_root,
    output t_meta                o_meta,
    output logic [2*RB-1:0]      o_rad,
    output logic [RB+1:0]        o_rem,
    output logic [RB-1:0]        o_root
);
    logic [RB+3:0] acc;
    logic [RB+3:0] trial;
    logic [RB+3:0] diff;
    logic          ge;
    t_meta         r_meta;
    logic [2*RB-1:0] r_rad;
    logic [RB+1:0] r_rem;
    logic [RB-1:0] r_root;

    always_comb begin
        acc   = {i_rem, i_rad[2*RB-1 -: 2]};
        trial = {2'b00, i_root, 2'b01};
        diff  = acc - trial;
        ge    = (acc >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta.valid <= 1'b0;
        end else if (i_en) begin
            r_meta.valid <= i_meta.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_meta.path <= i_meta.path;
            r_meta.dabs <= i_meta.dabs;
            r_meta.uv   <= i_meta.uv;
            r_rad       <= {i_rad[2*RB-3:0], 2'b00};
            r_rem       <= ge ? diff[RB+1:0] : acc[RB+1:0];
            r_root      <= {i_root[RB-2:0], ge};
        end
    end

    assign o_meta = r_meta;
    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;
endmodule
`default_nettype wire

// ----- hw/rtl/rttc_div_cell.sv -----
// One divider cell: restoring step that yields one quotient bit
`timescale 1ns / 1ps
`default_nettype none
module rttc_div_cell
    import rttc_pkg::*;
#(
    parameter int NW = 31,
    parameter int DW = 22
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire t_meta         i_meta,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [DW-1:0] i_rem,
    input  wire logic [NW-1:0] i_quo,
    output t_meta              o_meta,
    output logic [NW-1:0]      o_num,
    output logic [DW-1:0]      o_den,
    output logic [DW-1:0]      o_rem,
    output logic [NW-1:0]      o_quo
);
    logic [DW:0]   acc;
    logic [DW:0]   diff;
    logic          ge;
    t_meta         r_meta;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_quo;

    always_comb begin
        acc  = {i_rem, i_num[NW-1]};
        diff = acc - {1'b0, i_den};
        ge   = (acc >= {1'b0, i_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta.valid <= 1'b0;
        end else if (i_en) begin
            r_meta.valid <= i_meta.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_meta.path <= i_meta.path;
            r_meta.dabs <= i_meta.dabs;
            r_meta.uv   <= i_meta.uv;
            r_num       <= {i_num[NW-2:0], 1'b0};
            r_den       <= i_den;
            r_rem       <= ge ? diff[DW-1:0] : acc[DW-1:0];
            r_quo       <= {i_quo[NW-2:0], ge};
        end
    end

    assign o_meta = r_meta;
    assign o_num  = r_num;
    assign o_den  = r_den;
    assign o_rem  = r_rem;
    assign o_quo  = r_quo;
endmodule
`default_nettype wire

// ----- hw/rtl/rear_time_to_collision_unit.sv -----
// Rear time-to-collision unit: gap, root chain, divider chain and output skid
// Pipeline, F = (CALC_WIDTH-16)/4: 3 front stages, 17+F root cells, 27+F divider cells.
// Throughput: one beat per cycle unless the skid holds the pipe; the root and divider chains are one bit per cell.
// A one-beat skid at the output holds the pipe only after a stalled output beat.
// Synchronous active-low reset clears valid bits and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none
module rear_time_to_collision_unit
    import rttc_pkg::*;
#(
    parameter int CALC_WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [15:0]       i_target_long_pos,
    input  wire logic [11:0]       i_target_length,
    input  wire logic [15:0]       i_target_long_speed,
    input  wire logic [11:0]       i_target_long_accel,
    input  wire logic [15:0]       i_host_long_speed,
    input  wire logic [11:0]       i_host_long_accel,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [13:0]            o_ttc_ms,
    output logic [2:0]             o_path_taken,
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data
);
    localparam int RF   = (CALC_WIDTH - 16) / 4;
    localparam int RB   = 17 + RF;
    localparam int DW   = 18 + RF;
    localparam int NW   = 27 + RF;

    logic [9:0]  r_axle;
    logic [10:0] r_hlen;
    logic [13:0] r_def;
    logic [10:0] r_lat;
    logic [9:0]  r_vband;
    logic [9:0]  r_aband;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axle  <= 10'd100;
            r_hlen  <= 11'd480;
            r_def   <= 14'd10000;
            r_lat   <= 11'd100;
            r_vband <= 10'd10;
            r_aband <= 10'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_AXLE_OFFSET: r_axle  <= i_cfg_data[9:0];
                CFG_HOST_LENGTH: r_hlen  <= i_cfg_data[10:0];
                CFG_DEFAULT_TTC: r_def   <= i_cfg_data[13:0];
                CFG_LATENCY:     r_lat   <= i_cfg_data[10:0];
                CFG_SPEED_BAND:  r_vband <= i_cfg_data[9:0];
                CFG_ACCEL_BAND:  r_aband <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic r_sk_valid;
    assign en      = !r_sk_valid;
    assign o_stall = r_sk_valid;

    // stage 0: gap in half cm, relative speed and accel
    logic            r0_valid;
    logic [D2_W-1:0] r0_d2;
    logic [V_W-1:0]  r0_v;
    logic [A_W-1:0]  r0_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (en) begin
            r0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_d2 <= {i_target_long_pos[15], i_target_long_pos, 1'b0}
                     - {7'd0, r_axle, 1'b0} + {6'd0, r_hlen, 1'b0}
                     + {6'd0, i_target_length};
            r0_v  <= {i_target_long_speed[15], i_target_long_speed}
                     - {i_host_long_speed[15], i_host_long_speed};
            r0_a  <= {i_target_long_accel[11], i_target_long_accel}
                     - {i_host_long_accel[11], i_host_long_accel};
        end
    end

    // stage 1: products and case split
    logic [A_W-1:0]  aabs;
    logic [D2_W-1:0] d2neg;
    logic            ahead;
    logic            not_closing;
    logic            a_small;
    t_path           n1_path;
    t_meta           r1_meta;
    logic signed [33:0] r1_vv;
    logic signed [30:0] r1_ad;

    always_comb begin
        aabs        = r0_a[A_W-1] ? (A_W'(0) - r0_a) : r0_a;
        d2neg       = D2_W'(0) - r0_d2;
        ahead       = !r0_d2[D2_W-1];
        not_closing = r0_v[V_W-1] || (r0_v == '0) || (r0_v[V_W-2:0] < {6'd0, r_vband});
        a_small     = (r0_a == '0) || (aabs < {3'd0, r_aband});
        if (ahead) begin
            n1_path = PATH_AHEAD;
        end else if (not_closing) begin
            n1_path = PATH_NOT_CLOSING;
        end else if (a_small) begin
            n1_path = PATH_LINEAR;
        end else begin
            n1_path = PATH_ROOT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_meta.valid <= 1'b0;
        end else if (en) begin
            r1_meta.valid <= r0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_meta.path <= n1_path;
            r1_meta.dabs <= d2neg[MAG_W-1:0];
            r1_meta.uv   <= r0_v;
            r1_vv        <= $signed(r0_v) * $signed(r0_v);
            r1_ad        <= $signed(r0_a) * $signed(r0_d2);
        end
    end

    // stage 2: radicand
    logic signed [33:0] rad;
    t_meta              r2_meta;
    logic [2*RB-1:0]    r2_rad;

    assign rad = r1_vv - {{3{r1_ad[30]}}, r1_ad};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_meta.valid <= 1'b0;
        end else if (en) begin
            r2_meta.valid <= r1_meta.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_meta.path <= (r1_meta.path == PATH_ROOT && rad[33]) ? PATH_NO_REAL
                                                                   : r1_meta.path;
            r2_meta.dabs <= r1_meta.dabs;
            r2_meta.uv   <= r1_meta.uv;
            r2_rad       <= {rad, {(2*RF){1'b0}}};
        end
    end

    // root chain
    t_meta           sq_meta [0:RB];
    logic [2*RB-1:0] sq_rad  [0:RB];
    logic [RB+1:0]   sq_rem  [0:RB];
    logic [RB-1:0]   sq_root [0:RB];

    assign sq_meta[0] = r2_meta;
    assign sq_rad[0]  = r2_rad;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar g = 0; g < RB; g++) begin : g_sqrt
        rttc_sqrt_cell #(.RB(RB)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_meta  (sq_meta[g]),
            .i_rad   (sq_rad[g]),
            .i_rem   (sq_rem[g]),
            .i_root  (sq_root[g]),
            .o_meta  (sq_meta[g+1]),
            .o_rad   (sq_rad[g+1]),
            .o_rem   (sq_rem[g+1]),
            .o_root  (sq_root[g+1])
        );
    end

    // stage 3: divider operands
    t_meta         sq_out;
    logic [26:0]   p500;
    logic [26:0]   p1000;
    t_meta         r3_meta;
    logic [NW-1:0] r3_num;
    logic [DW-1:0] r3_den;

    always_comb begin
        sq_out = sq_meta[RB];
        p500   = 27'(sq_out.dabs) * 27'd500;
        p1000  = 27'(sq_out.dabs) * 27'd1000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_meta.valid <= 1'b0;
        end else if (en) begin
            r3_meta.valid <= sq_out.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_meta.path <= sq_out.path;
            r3_meta.dabs <= sq_out.dabs;
            r3_meta.uv   <= sq_out.uv;
            if (sq_out.path == PATH_LINEAR) begin
                r3_num <= {{RF{1'b0}}, p500};
                r3_den <= {{(RF+1){1'b0}}, sq_out.uv};
            end else begin
                r3_num <= {p1000, {RF{1'b0}}};
                r3_den <= {1'b0, sq_out.uv, {RF{1'b0}}} + {1'b0, sq_root[RB]};
            end
        end
    end

    // divider chain
    t_meta         dv_meta [0:NW];
    logic [NW-1:0] dv_num  [0:NW];
    logic [DW-1:0] dv_den  [0:NW];
    logic [DW-1:0] dv_rem  [0:NW];
    logic [NW-1:0] dv_quo  [0:NW];

    assign dv_meta[0] = r3_meta;
    assign dv_num[0]  = r3_num;
    assign dv_den[0]  = r3_den;
    assign dv_rem[0]  = '0;
    assign dv_quo[0]  = '0;

    for (genvar g = 0; g < NW; g++) begin : g_div
        rttc_div_cell #(.NW(NW), .DW(DW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_meta  (dv_meta[g]),
            .i_num   (dv_num[g]),
            .i_den   (dv_den[g]),
            .i_rem   (dv_rem[g]),
            .i_quo   (dv_quo[g]),
            .o_meta  (dv_meta[g+1]),
            .o_num   (dv_num[g+1]),
            .o_den   (dv_den[g+1]),
            .o_rem   (dv_rem[g+1]),
            .o_quo   (dv_quo[g+1])
        );
    end

    // stage 5: latency, floor and clamp
    t_meta         dv_out;
    logic [NW-1:0] t_sub;
    logic [13:0]   n5_ttc;
    logic          r5_valid;
    logic [13:0]   r5_ttc;
    logic [2:0]    r5_path;

    always_comb begin
        dv_out = dv_meta[NW];
        t_sub  = (dv_quo[NW] <= NW'(r_lat)) ? '0 : dv_quo[NW] - NW'(r_lat);
        if (dv_out.path == PATH_LINEAR || dv_out.path == PATH_ROOT) begin
            n5_ttc = (t_sub > NW'(r_def)) ? r_def : t_sub[13:0];
        end else begin
            n5_ttc = r_def;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (en) begin
            r5_valid <= dv_out.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_ttc  <= n5_ttc;
            r5_path <= dv_out.path;
        end
    end

    // output register and one-beat skid
    logic        r_out_valid;
    logic [13:0] r_out_ttc;
    logic [2:0]  r_out_path;
    logic [13:0] r_sk_ttc;
    logic [2:0]  r_sk_path;
    logic        take;

    assign take = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (take) begin
            r_out_valid <= r_sk_valid || (en && r5_valid);
            r_sk_valid  <= 1'b0;
        end else if (en && r5_valid) begin
            r_sk_valid  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_ttc  <= r_sk_valid ? r_sk_ttc : r5_ttc;
            r_out_path <= r_sk_valid ? r_sk_path : r5_path;
        end else if (en && r5_valid) begin
            r_sk_ttc  <= r5_ttc;
            r_sk_path <= r5_path;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_ttc_ms     = r_out_ttc;
    assign o_path_taken = r_out_path;
endmodule
`default_nettype wire

// ----- hw/rtl/rttc_checker.sv -----
// Port-level checks for the rear time-to-collision unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rttc_checker
    import rttc_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [2:0]  o_path_taken
);
    // input side only stalls after a stalled output beat
    `CHK_SAME(a_stall_cause, i_clk, i_rst_n, $rose(o_stall), $past(o_valid && i_stall))
    // stall clears the cycle after the output beat is taken
    `CHK_NEXT(a_stall_release, i_clk, i_rst_n, o_stall && !i_stall, !o_stall)
    // held output beat stays valid
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    // output path code is one the unit produces, never PATH_NO_POS
    `CHK_SAME(a_path_code, i_clk, i_rst_n, o_valid,
              o_path_taken != PATH_NO_POS && o_path_taken <= PATH_NO_REAL)
endmodule

bind rear_time_to_collision_unit rttc_checker u_rttc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_path_taken (o_path_taken)
);
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the rear time-to-collision unit
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import rttc_pkg::*;

    localparam int ROOT_F     = (32 - 16) / 4;
    localparam int PIPE_DEPTH = 50 + 2 * ROOT_F;
    localparam int CYCLE_CAP  = 600000;

    typedef struct {
        int pos, len, tv, ta, hv, ha;
        bit known;
        int ttc;
        t_path path;
    } t_obj_row;

    typedef struct {
        logic [13:0] ttc;
        t_path       path;
    } t_ttc_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [15:0]       i_target_long_pos;
    logic [11:0]       i_target_length;
    logic [15:0]       i_target_long_speed;
    logic [11:0]       i_target_long_accel;
    logic [15:0]       i_host_long_speed;
    logic [11:0]       i_host_long_accel;
    logic              o_valid;
    logic              i_stall;
    logic [13:0]       o_ttc_ms;
    logic [2:0]        o_path_taken;
    logic              i_cfg_we;
    logic [IDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;

    rear_time_to_collision_unit i_dut (.*);

    // register copies
    logic [9:0]  axle_off;
    logic [10:0] host_len;
    logic [13:0] dflt_ttc;
    logic [10:0] latency;
    logic [9:0]  speed_band;
    logic [9:0]  accel_band;

    t_ttc_result pending_ttc[$];
    int  mismatches;
    bit  failed;
    bit  quiet;
    bit  hold_req;
    int  cycles;
    int  sent;

    t_obj_row directed_rows[15] = '{
        '{0, 0, 0, 0, 0, 0, 1, 10000, PATH_AHEAD},
        '{32767, 4095, 32767, 2047, 32767, 2047, 1, 10000, PATH_AHEAD},
        '{-32768, 4095, 32767, 2047, -32768, -2048, 0, 0, PATH_AHEAD},
        '{-1000, 0, 0, 0, 0, 0, 1, 10000, PATH_NOT_CLOSING},
        '{-1000, 0, 5, 0, 0, 0, 1, 10000, PATH_NOT_CLOSING},
        '{-1000, 0, -100, 0, 0, 0, 1, 10000, PATH_NOT_CLOSING},
        '{-1000, 0, 100, 0, 0, 0, 1, 6100, PATH_LINEAR},
        '{-1000, 0, 100, 9, 0, 0, 0, 0, PATH_AHEAD},
        '{-1000, 0, 100, 10, 0, 0, 0, 0, PATH_AHEAD},
        '{-1000, 0, 20, -2000, 0, 0, 1, 10000, PATH_NO_REAL},
        '{-381, 0, 1000, 0, 0, 0, 1, 0, PATH_LINEAR},
        '{-32768, 0, 10, 0, 0, 0, 1, 10000, PATH_LINEAR},
        '{-32768, 0, -32768, -2048, 32767, 2047, 1, 10000, PATH_NOT_CLOSING},
        '{-1000, 0, 1000, -100, 0, 0, 0, 0, PATH_AHEAD},
        '{-5000, 37, 32767, 300, 0, -700, 0, 0, PATH_AHEAD}
    };

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned apply_latency(input longint unsigned t);
        longint unsigned r;
        r = (t <= latency) ? 0 : t - latency;
        return (r > dflt_ttc) ? dflt_ttc : r;
    endfunction

    function automatic t_ttc_result predict_ttc(input logic [15:0] pos, input logic [11:0] len,
                                                input logic [15:0] tv, input logic [11:0] ta,
                                                input logic [15:0] hv, input logic [11:0] ha);
        longint d2, v, a, aabs, rad;
        longint unsigned dabs, root, den, num;
        t_ttc_result res;
        d2 = 2 * longint'($signed(pos)) - 2 * longint'(axle_off) + 2 * longint'(host_len)
             + longint'(len);
        v = longint'($signed(tv)) - longint'($signed(hv));
        a = longint'($signed(ta)) - longint'($signed(ha));
        aabs = (a < 0) ? -a : a;
        res.ttc = dflt_ttc;
        if (d2 >= 0) begin
            res.path = PATH_AHEAD;
        end else if (v <= 0 || v < longint'(speed_band)) begin
            res.path = PATH_NOT_CLOSING;
        end else begin
            dabs = -d2;
            if (a == 0 || aabs < longint'(accel_band)) begin
                res.ttc = 14'(apply_latency((500 * dabs) / v));
                res.path = PATH_LINEAR;
            end else begin
                rad = v * v - a * d2;
                if (rad < 0) begin
                    res.path = PATH_NO_REAL;
                end else begin
                    root = int_sqrt(longint'(rad) << (2 * ROOT_F));
                    den = (longint'(v) << ROOT_F) + root;
                    num = (1000 * dabs) << ROOT_F;
                    res.ttc = 14'(apply_latency(num / den));
                    res.path = PATH_ROOT;
                end
            end
        end
        return res;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_ttc_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_ttc.size() == 0) begin
                failed = 1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: ttc=%0d path=%0d", o_ttc_ms, o_path_taken);
            end else begin
                exp_r = pending_ttc.pop_front();
                if (o_ttc_ms !== exp_r.ttc || o_path_taken !== exp_r.path) begin
                    failed = 1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp ttc=%0d path=%0d, got ttc=%0d path=%0d",
                                 exp_r.ttc, exp_r.path, o_ttc_ms, o_path_taken);
                end
            end
        end
    end

    // receiver backpressure
    initial begin
        int n;
        i_stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1;
                repeat (300) @(negedge i_clk);
                hold_req = 0;
                i_stall <= 0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 6);
                i_stall <= 1;
                repeat (n) @(negedge i_clk);
                i_stall <= 0;
            end
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_AXLE_OFFSET: axle_off = val[9:0];
            CFG_HOST_LENGTH: host_len = val[10:0];
            CFG_DEFAULT_TTC: dflt_ttc = val[13:0];
            CFG_LATENCY:     latency = val[10:0];
            CFG_SPEED_BAND:  speed_band = val[9:0];
            CFG_ACCEL_BAND:  accel_band = val[9:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic drain();
        while (pending_ttc.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
    endtask

    // drives one beat; leaves valid high after acceptance
    task automatic send_object(input logic [15:0] pos, input logic [11:0] len,
                               input logic [15:0] tv, input logic [11:0] ta,
                               input logic [15:0] hv, input logic [11:0] ha,
                               output t_ttc_result got);
        int gap;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 6);
            i_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1;
        i_target_long_pos <= pos;
        i_target_length <= len;
        i_target_long_speed <= tv;
        i_target_long_accel <= ta;
        i_host_long_speed <= hv;
        i_host_long_accel <= ha;
        do @(posedge i_clk); while (o_stall);
        got = predict_ttc(pos, len, tv, ta, hv, ha);
        pending_ttc.push_back(got);
        sent++;
    endtask

    task automatic send_random(input int count, input int phase_total_left);
        logic [15:0] pos, tv, hv;
        logic [11:0] len, ta, ha;
        t_ttc_result r;
        int k;
        for (k = 0; k < count; k++) begin
            if (sent == 400) hold_req = 1;
            if (sent == 700) begin
                @(negedge i_clk);
                i_valid <= 0;
                while (pending_ttc.size() != 0) @(posedge i_clk);
            end
            if (phase_total_left - k <= 120) quiet = 1;
            {pos, tv, hv} = 48'({$urandom, $urandom});
            {len, ta, ha} = 36'({$urandom, $urandom});
            if ($urandom_range(0, 3) != 0) begin
                // mostly closing objects behind: small non-positive position, non-negative closing speed
                pos = 16'(-$urandom_range(0, 4000));
                len = 12'($urandom_range(0, 600));
                hv = 16'($urandom_range(0, 3000));
                tv = hv + 16'($urandom_range(0, 2500));
                ta = $urandom_range(0, 1) ? 12'($urandom_range(0, 30)) - 12'd15
                                          : 12'($urandom);
                ha = $urandom_range(0, 1) ? 12'd0 : 12'($urandom_range(0, 400)) - 12'd200;
            end
            send_object(pos, len, tv, ta, hv, ha, r);
        end
    endtask

    initial begin
        t_ttc_result r;
        int i, p;
        sent = 0;
        mismatches = 0;
        failed = 0;
        quiet = 0;
        hold_req = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_cfg_we = 0;
        i_cfg_index = CFG_AXLE_OFFSET;
        i_cfg_data = 0;
        {i_target_long_pos, i_target_length, i_target_long_speed} = '0;
        {i_target_long_accel, i_host_long_speed, i_host_long_accel} = '0;
        axle_off = 100;
        host_len = 480;
        dflt_ttc = 10000;
        latency = 100;
        speed_band = 10;
        accel_band = 10;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed beats at reset register values
        for (i = 0; i < 15; i++) begin
            send_object(16'(directed_rows[i].pos), 12'(directed_rows[i].len),
                        16'(directed_rows[i].tv), 12'(directed_rows[i].ta),
                        16'(directed_rows[i].hv), 12'(directed_rows[i].ha), r);
            if (directed_rows[i].known &&
                (r.ttc != directed_rows[i].ttc || r.path != directed_rows[i].path)) begin
                void'(pending_ttc.pop_back());
                r.ttc = 14'(directed_rows[i].ttc);
                r.path = directed_rows[i].path;
                pending_ttc.push_back(r);
            end
        end
        send_random(200, 1000);

        for (p = 0; p < 4; p++) begin
            @(negedge i_clk);
            i_valid <= 0;
            drain();
            for (i = 0; i < 6; i++) begin
                case (p)
                    0: write_reg(IDX_W'(i), '0);
                    1: write_reg(IDX_W'(i), '1);
                    default: write_reg(IDX_W'(i), CFG_W'($urandom));
                endcase
            end
            if (p == 3) begin
                write_reg(CFG_DEFAULT_TTC, 14'd16383);
                write_reg(CFG_SPEED_BAND, 14'd10);
            end
            // zero bands: zero acceleration must still take the linear path
            if (p == 0) begin
                send_object(-16'd1000, 12'd0, 16'd100, 12'd0, 16'd0, 12'd0, r);
                send_object(-16'd1000, 12'd0, 16'd100, 12'd1, 16'd0, 12'd0, r);
            end
            send_random(225, (p == 3) ? 225 : 100000);
        end

        @(negedge i_clk);
        i_valid <= 0;
        while (pending_ttc.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
        if (!failed)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
